// ===== src/t8ce_pkg.sv =====
`timescale 1ns / 1ps

package t8ce_pkg;

  localparam int DATA_W = 8;
  localparam int OP_W   = 4;
  localparam int RSEL_W = 3;
  localparam int ADDR_W = 8;

  typedef enum logic [OP_W-1:0] {
    OP_INPUT  = 4'd0,
    OP_OUTPUT = 4'd1,
    OP_ADD    = 4'd2,
    OP_SUB    = 4'd3,
    OP_MUL    = 4'd4,
    OP_JUMP   = 4'd5,
    OP_BEQ    = 4'd6,
    OP_LOAD   = 4'd7,
    OP_STORE  = 4'd8,
    OP_HALT   = 4'd9
  } op_code_t;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [RSEL_W-1:0] reg_a;
    logic [RSEL_W-1:0] reg_b;
    logic [RSEL_W-1:0] reg_c;
    logic [ADDR_W-1:0] target_addr;
    logic [DATA_W-1:0] in_value;
  } in_item_t;

  typedef struct packed {
    logic [ADDR_W-1:0] next_pc;
    logic [DATA_W-1:0] out_value;
    logic              out_valid;
    logic              halted;
    logic              bad_opcode;
  } out_item_t;

endpackage

// ===== src/toy_8bit_cpu_execute_unit.sv =====
`timescale 1ns / 1ps

// Execute unit of a small 8-bit register machine: one decoded instruction per
// transfer, one result per instruction, in order. Sustains one instruction per
// clock while a full result register is not held by a low out_ready; a result
// passes through the operand stage, then the result register. The register
// file and data store are RAMs with registered reads issued on the input
// transfer; results written by the instruction ahead are forwarded. Reset state
// (all registers and data bytes zero) is held in per-entry valid flops, so no
// clearing pass is needed and the block accepts input in the first cycle after reset.
module toy_8bit_cpu_execute_unit
  import t8ce_pkg::*;
#(
  parameter int NUM_REGS   = 8,
  parameter int DATA_DEPTH = 256
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  localparam int RIDX_W = $clog2(NUM_REGS);
  localparam int DIDX_W = $clog2(DATA_DEPTH);

  // pipeline control
  logic      s1_vld_r;
  in_item_t  s1_item_r;
  logic      out_vld_r;
  out_item_t out_item_r;
  logic      in_fire;
  logic      exec_fire;

  // architectural state
  logic [ADDR_W-1:0] pc_r;
  logic [ADDR_W-1:0] pc_nxt;
  logic              halt_r;
  logic              halt_nxt;
  logic              rf_vld_r [NUM_REGS];
  logic              ds_vld_r [DATA_DEPTH];

  // operand selection at transfer time
  logic [RSEL_W-1:0] x_sel;
  logic [RSEL_W-1:0] y_sel;
  logic              x_in;
  logic              y_in;
  logic              d_in;
  logic [RIDX_W-1:0] x_idx;
  logic [RIDX_W-1:0] y_idx;
  logic [DIDX_W-1:0] d_idx;
  logic              x_fwd_nxt;
  logic              y_fwd_nxt;
  logic              d_fwd_nxt;

  // operand stage side registers
  logic              x_ok_r;
  logic              y_ok_r;
  logic              d_ok_r;
  logic              x_fwd_r;
  logic              y_fwd_r;
  logic              d_fwd_r;
  logic [DATA_W-1:0] rf_fwd_r;
  logic [DATA_W-1:0] ds_fwd_r;

  // ram ports
  logic [DATA_W-1:0] rf_rd_x;
  logic [DATA_W-1:0] rf_rd_y;
  logic [DATA_W-1:0] ds_rd;
  logic              rf_we;
  logic [RIDX_W-1:0] rf_waddr;
  logic [DATA_W-1:0] rf_wdata;
  logic              ds_we;
  logic [DIDX_W-1:0] ds_waddr;
  logic [DATA_W-1:0] ds_wdata;

  // execute
  logic [DATA_W-1:0]   x_val;
  logic [DATA_W-1:0]   y_val;
  logic [DATA_W-1:0]   ld_val;
  logic [2*DATA_W-1:0] prod;
  logic                a_in;
  logic                d_exec_in;
  logic                rf_wreq;
  logic                ds_wreq;
  out_item_t           res;

  assign exec_fire = s1_vld_r && (!out_vld_r || out_ready);
  assign in_ready  = !s1_vld_r || exec_fire;
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_vld_r;
  assign out_data  = out_item_r;

  // port x: arithmetic first source, else reg_a; port y: BEQ compare, else reg_c
  always_comb begin
    x_sel = in_data.reg_a;
    y_sel = in_data.reg_c;
    case (in_data.op)
      OP_ADD, OP_SUB, OP_MUL: x_sel = in_data.reg_b;
      OP_BEQ:                 y_sel = in_data.reg_b;
      default: ;
    endcase
  end

  assign x_in  = {2'b00, x_sel} < 5'(NUM_REGS);
  assign y_in  = {2'b00, y_sel} < 5'(NUM_REGS);
  assign d_in  = {1'b0, in_data.target_addr} < 9'(DATA_DEPTH);
  assign x_idx = RIDX_W'(x_sel);
  assign y_idx = RIDX_W'(y_sel);
  assign d_idx = DIDX_W'(in_data.target_addr);

  // a write committing on the same edge as the read is not seen by the RAM
  assign x_fwd_nxt = rf_we && (rf_waddr == x_idx);
  assign y_fwd_nxt = rf_we && (rf_waddr == y_idx);
  assign d_fwd_nxt = ds_we && (ds_waddr == d_idx);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_ready) begin
      s1_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_item_r <= in_data;
      x_fwd_r   <= x_fwd_nxt;
      y_fwd_r   <= y_fwd_nxt;
      d_fwd_r   <= d_fwd_nxt;
      x_ok_r    <= x_in && (rf_vld_r[x_idx] || x_fwd_nxt);
      y_ok_r    <= y_in && (rf_vld_r[y_idx] || y_fwd_nxt);
      d_ok_r    <= d_in && (ds_vld_r[d_idx] || d_fwd_nxt);
      rf_fwd_r  <= rf_wdata;
      ds_fwd_r  <= ds_wdata;
    end
  end

  t8ce_ram #(
    .WIDTH (DATA_W),
    .DEPTH (NUM_REGS)
  ) u_reg_file (
    .clk     (clk),
    .we      (rf_we),
    .waddr   (rf_waddr),
    .wdata   (rf_wdata),
    .re      (in_fire),
    .raddr_a (x_idx),
    .rdata_a (rf_rd_x),
    .raddr_b (y_idx),
    .rdata_b (rf_rd_y)
  );

  t8ce_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DATA_DEPTH)
  ) u_data_store (
    .clk     (clk),
    .we      (ds_we),
    .waddr   (ds_waddr),
    .wdata   (ds_wdata),
    .re      (in_fire),
    .raddr_a (d_idx),
    .rdata_a (ds_rd),
    .raddr_b (d_idx),
    .rdata_b ()
  );

  // unwritten entries and out-of-range indices read as zero
  assign x_val  = x_ok_r ? (x_fwd_r ? rf_fwd_r : rf_rd_x) : '0;
  assign y_val  = y_ok_r ? (y_fwd_r ? rf_fwd_r : rf_rd_y) : '0;
  assign ld_val = d_ok_r ? (d_fwd_r ? ds_fwd_r : ds_rd) : '0;
  assign prod   = x_val * y_val;

  assign a_in      = {2'b00, s1_item_r.reg_a} < 5'(NUM_REGS);
  assign d_exec_in = {1'b0, s1_item_r.target_addr} < 9'(DATA_DEPTH);
  assign rf_waddr  = RIDX_W'(s1_item_r.reg_a);
  assign ds_waddr  = DIDX_W'(s1_item_r.target_addr);
  assign ds_wdata  = x_val;

  always_comb begin
    pc_nxt   = pc_r;
    halt_nxt = halt_r;
    rf_wreq  = 1'b0;
    ds_wreq  = 1'b0;
    rf_wdata = s1_item_r.in_value;
    res      = '0;
    if (!halt_r) begin
      pc_nxt = pc_r + 8'd1;
      case (s1_item_r.op)
        OP_INPUT: begin
          rf_wreq = 1'b1;
        end
        OP_OUTPUT: begin
          res.out_value = x_val;
          res.out_valid = 1'b1;
        end
        OP_ADD: begin
          rf_wreq  = 1'b1;
          rf_wdata = x_val + y_val;
        end
        OP_SUB: begin
          rf_wreq  = 1'b1;
          rf_wdata = x_val - y_val;
        end
        OP_MUL: begin
          rf_wreq  = 1'b1;
          rf_wdata = prod[DATA_W-1:0];
        end
        OP_JUMP: begin
          pc_nxt = s1_item_r.target_addr;
        end
        OP_BEQ: begin
          if (x_val == y_val) begin
            pc_nxt = s1_item_r.target_addr;
          end
        end
        OP_LOAD: begin
          rf_wreq  = 1'b1;
          rf_wdata = ld_val;
        end
        OP_STORE: begin
          ds_wreq = 1'b1;
        end
        OP_HALT: begin
          halt_nxt = 1'b1;
        end
        default: begin
          res.bad_opcode = 1'b1;
        end
      endcase
    end
    res.next_pc = pc_nxt;
    res.halted  = halt_nxt;
  end

  assign rf_we = exec_fire && rf_wreq && a_in;
  assign ds_we = exec_fire && ds_wreq && d_exec_in;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r   <= '0;
      halt_r <= 1'b0;
    end else if (exec_fire) begin
      pc_r   <= pc_nxt;
      halt_r <= halt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        rf_vld_r[i] <= 1'b0;
      end
    end else if (rf_we) begin
      rf_vld_r[rf_waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DATA_DEPTH; i++) begin
        ds_vld_r[i] <= 1'b0;
      end
    end else if (ds_we) begin
      ds_vld_r[ds_waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (exec_fire) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_fire) begin
      out_item_r <= res;
    end
  end

endmodule

// ===== src/t8ce_ram.sv =====
`timescale 1ns / 1ps

module t8ce_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic [WIDTH-1:0]         rdata_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_a_r;
  logic [WIDTH-1:0] rdata_b_r;

  // read-during-write returns the old contents
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a_r <= mem[raddr_a];
      rdata_b_r <= mem[raddr_b];
    end
  end

  assign rdata_a = rdata_a_r;
  assign rdata_b = rdata_b_r;

endmodule
